### design/tsm_pkg.sv
// Shared types and constants for the two-register stack machine step core.
// Holds the word layouts, opcode/status/action codes and the engine states.
// No dependencies.
`timescale 1ns / 1ps

package tsm_pkg;

   localparam int          DATA_W      = 32;
   localparam int          ADDR_FLD_W  = 12;
   localparam int          LIMIT_W     = 13;
   localparam logic [12:0] LIMIT_RESET = 13'd4095;
   localparam logic [31:0] SP_RESET    = 32'd2048;

   typedef enum logic [1:0] {
      ACT_WRITE   = 2'd0,
      ACT_READ    = 2'd1,
      ACT_STEP    = 2'd2,
      ACT_RESTART = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_DONE    = 3'd0,
      ST_HALT    = 3'd1,
      ST_UNKNOWN = 3'd2,
      ST_PAST    = 3'd3,
      ST_STOPPED = 3'd4
   } status_type;

   typedef enum logic [7:0] {
      OP_LDC    = 8'd0,
      OP_ADC    = 8'd1,
      OP_LDL    = 8'd2,
      OP_STL    = 8'd3,
      OP_LDNL   = 8'd4,
      OP_STNL   = 8'd5,
      OP_ADD    = 8'd6,
      OP_SUB    = 8'd7,
      OP_SHL    = 8'd8,
      OP_SHR    = 8'd9,
      OP_ADJ    = 8'd10,
      OP_A2SP   = 8'd11,
      OP_SP2A   = 8'd12,
      OP_CALL   = 8'd13,
      OP_RETURN = 8'd14,
      OP_BRZ    = 8'd15,
      OP_BRLZ   = 8'd16,
      OP_BR     = 8'd17,
      OP_HALT   = 8'd18
   } opcode_type;

   typedef enum logic {
      CSR_RUN_LIMIT   = 1'b0,
      CSR_STACK_START = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ENG_CLEAR,
      ENG_IDLE,
      ENG_RDATA,
      ENG_EXEC,
      ENG_LOAD
   } eng_state_type;

   typedef struct packed {
      logic [1:0]            action;
      logic [ADDR_FLD_W-1:0] address;
      logic [DATA_W-1:0]     write_data;
   } req_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [DATA_W-1:0] read_data;
      logic [7:0]        opcode_done;
      logic [DATA_W-1:0] pc_out;
      logic [DATA_W-1:0] sp_out;
      logic [DATA_W-1:0] a_out;
      logic [DATA_W-1:0] b_out;
   } rsp_type;

   typedef struct packed {
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
      logic [DATA_W-1:0] pc;
      logic [DATA_W-1:0] sp;
   } regs_type;

   // execute unit result for one instruction word
   typedef struct packed {
      regs_type          regs;
      status_type        status;
      logic              stop;
      logic              load;
      logic              store;
      logic [DATA_W-1:0] mem_addr;
      logic [DATA_W-1:0] wdata;
   } exec_res_type;

endpackage

### design/tsm_mem.sv
// Single-port synchronous word memory with a registered read.
// Read data holds until the next read. Uses tsm_pkg for the word width.
`timescale 1ns / 1ps

module tsm_mem
   import tsm_pkg::*;
#(
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [DATA_W-1:0]        wdata,
   output logic [DATA_W-1:0]        rdata
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en && we) begin
         mem_ff[addr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (en && !we) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### design/tsm_exec.sv
// Instruction execute unit: decodes one fetched word against the current
// registers and returns the new registers plus any memory access needed.
// Uses tsm_pkg types.
`timescale 1ns / 1ps

module tsm_exec
   import tsm_pkg::*;
(
   input  logic [DATA_W-1:0] word,
   input  regs_type          cur,
   output exec_res_type      res
);

   logic [7:0]        op;
   logic [DATA_W-1:0] val;
   logic [DATA_W-1:0] pc_inc;
   logic [DATA_W-1:0] pc_tgt;
   logic [DATA_W-1:0] a_val;
   logic [DATA_W-1:0] sp_val;
   logic [DATA_W-1:0] shl_res;
   logic [DATA_W-1:0] shr_res;
   logic              big_shift;

   assign op     = word[7:0];
   assign val    = {{8{word[31]}}, word[31:8]};
   assign pc_inc = cur.pc + 32'd1;
   assign pc_tgt = pc_inc + val;
   assign a_val  = cur.a + val;
   assign sp_val = cur.sp + val;

   // count taken unsigned; 32 or more saturates
   assign big_shift = |cur.a[31:5];
   assign shl_res   = big_shift ? '0 : (cur.b << cur.a[4:0]);
   assign shr_res   = big_shift ? {DATA_W{cur.b[31]}}
                                : DATA_W'($signed(cur.b) >>> cur.a[4:0]);

   always_comb begin
      res          = '0;
      res.regs     = cur;
      res.regs.pc  = pc_inc;
      res.status   = ST_DONE;
      res.stop     = 1'b0;
      res.load     = 1'b0;
      res.store    = 1'b0;
      res.mem_addr = sp_val;
      res.wdata    = cur.a;
      unique case (op)
         OP_LDC: begin
            res.regs.b = cur.a;
            res.regs.a = val;
         end
         OP_ADC: res.regs.a = a_val;
         OP_LDL: begin
            res.regs.b   = cur.a;
            res.load     = 1'b1;
            res.mem_addr = sp_val;
         end
         OP_STL: begin
            res.store    = 1'b1;
            res.mem_addr = sp_val;
            res.wdata    = cur.a;
            res.regs.a   = cur.b;
         end
         OP_LDNL: begin
            res.load     = 1'b1;
            res.mem_addr = a_val;
         end
         OP_STNL: begin
            res.store    = 1'b1;
            res.mem_addr = a_val;
            res.wdata    = cur.b;
         end
         OP_ADD: res.regs.a = cur.b + cur.a;
         OP_SUB: res.regs.a = cur.b - cur.a;
         OP_SHL: res.regs.a = shl_res;
         OP_SHR: res.regs.a = shr_res;
         OP_ADJ: res.regs.sp = sp_val;
         OP_A2SP: begin
            res.regs.sp = cur.a;
            res.regs.a  = cur.b;
         end
         OP_SP2A: begin
            res.regs.b = cur.a;
            res.regs.a = cur.sp;
         end
         OP_CALL: begin
            res.regs.b  = cur.a;
            res.regs.a  = pc_inc;
            res.regs.pc = pc_tgt;
         end
         OP_RETURN: begin
            res.regs.pc = cur.a;
            res.regs.a  = cur.b;
         end
         OP_BRZ: begin
            if (cur.a == '0) begin
               res.regs.pc = pc_tgt;
            end
         end
         OP_BRLZ: begin
            if (cur.a[31]) begin
               res.regs.pc = pc_tgt;
            end
         end
         OP_BR: res.regs.pc = pc_tgt;
         OP_HALT: begin
            res.stop   = 1'b1;
            res.status = ST_HALT;
         end
         default: begin
            res.stop   = 1'b1;
            res.status = ST_UNKNOWN;
         end
      endcase
   end

endmodule

### design/two_register_stack_machine_step_core.sv
// Two-register stack machine step core. Each input word is a memory write, a
// memory read, one instruction step or a restart; each gives one result word.
// All state sits in one single-port memory of MEM_WORDS words (a power of two)
// plus the A, B, PC, SP, stopped and config registers. After reset the core
// zeroes every memory word and takes no input words meanwhile; config writes
// are taken at any time. The engine takes one word at a time: a write or
// restart ends in idle, a read in the read-data state, a step in exec, ldl/ldnl
// in a load state after exec (fetch, then data read); a stopped or past-limit
// step ends in idle. An input register and an output register let the next
// word be taken while a result waits on the result side.
`timescale 1ns / 1ps

module two_register_stack_machine_step_core
   import tsm_pkg::*;
#(
   parameter int MEM_WORDS = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_payload,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [DATA_W-1:0] csr_wdata
);

   localparam int AW = $clog2(MEM_WORDS);

   eng_state_type      state_ff, state_in;
   logic [AW-1:0]      clr_cnt_ff, clr_cnt_in;
   logic               in_valid_ff;
   req_type            in_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff, rsp_in;
   regs_type           regs_ff, regs_in;
   logic               stopped_ff, stopped_in;
   logic [7:0]         op_ff, op_in;
   logic [LIMIT_W-1:0] run_limit_ff;
   logic [DATA_W-1:0]  stack_start_ff;

   logic               mem_en;
   logic               mem_we;
   logic [AW-1:0]      mem_addr;
   logic [DATA_W-1:0]  mem_wdata;
   logic [DATA_W-1:0]  mem_rdata;

   exec_res_type       ex;
   action_type         act;
   status_type         status;
   logic [DATA_W-1:0]  rd_word;
   logic [7:0]         opc;
   logic               take;
   logic               done;
   logic               out_free;
   logic               past;

   tsm_mem #(
      .DEPTH (MEM_WORDS)
   ) u_mem (
      .clock (clock),
      .en    (mem_en),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   tsm_exec u_exec (
      .word (mem_rdata),
      .cur  (regs_ff),
      .res  (ex)
   );

   assign act      = action_type'(in_ff.action);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign past     = regs_ff.pc > {{(DATA_W-LIMIT_W){1'b0}}, run_limit_ff};

   assign req_stall   = (state_ff == ENG_CLEAR) || (in_valid_ff && !take);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ENG_CLEAR: begin
            if (clr_cnt_ff == AW'(MEM_WORDS - 1)) begin
               state_in = ENG_IDLE;
            end
         end
         ENG_IDLE: begin
            if (in_valid_ff) begin
               if (act == ACT_READ) begin
                  state_in = ENG_RDATA;
               end else if (act == ACT_STEP && !stopped_ff && !past) begin
                  state_in = ENG_EXEC;
               end
            end
         end
         ENG_RDATA: begin
            if (out_free) begin
               state_in = ENG_IDLE;
            end
         end
         ENG_EXEC: begin
            if (ex.load) begin
               state_in = ENG_LOAD;
            end else if (out_free) begin
               state_in = ENG_IDLE;
            end
         end
         ENG_LOAD: begin
            if (out_free) begin
               state_in = ENG_IDLE;
            end
         end
         default: state_in = ENG_IDLE;
      endcase
   end

   // engine outputs: memory port, register updates, result
   always_comb begin
      take       = 1'b0;
      done       = 1'b0;
      mem_en     = 1'b0;
      mem_we     = 1'b0;
      mem_addr   = regs_ff.pc[AW-1:0];
      mem_wdata  = regs_ff.a;
      regs_in    = regs_ff;
      stopped_in = stopped_ff;
      op_in      = op_ff;
      clr_cnt_in = clr_cnt_ff;
      status     = ST_DONE;
      rd_word    = '0;
      opc        = '0;
      unique case (state_ff)
         ENG_CLEAR: begin
            mem_en     = 1'b1;
            mem_we     = 1'b1;
            mem_addr   = clr_cnt_ff;
            mem_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
         end
         ENG_IDLE: begin
            if (in_valid_ff) begin
               unique case (act)
                  ACT_WRITE: begin
                     if (out_free) begin
                        take      = 1'b1;
                        done      = 1'b1;
                        mem_en    = 1'b1;
                        mem_we    = 1'b1;
                        mem_addr  = AW'(in_ff.address);
                        mem_wdata = in_ff.write_data;
                     end
                  end
                  ACT_READ: begin
                     take     = 1'b1;
                     mem_en   = 1'b1;
                     mem_addr = AW'(in_ff.address);
                  end
                  ACT_STEP: begin
                     if (stopped_ff || past) begin
                        if (out_free) begin
                           take   = 1'b1;
                           done   = 1'b1;
                           status = stopped_ff ? ST_STOPPED : ST_PAST;
                        end
                     end else begin
                        // instruction fetch
                        take     = 1'b1;
                        mem_en   = 1'b1;
                        mem_addr = regs_ff.pc[AW-1:0];
                     end
                  end
                  ACT_RESTART: begin
                     if (out_free) begin
                        take       = 1'b1;
                        done       = 1'b1;
                        regs_in.a  = '0;
                        regs_in.b  = '0;
                        regs_in.pc = '0;
                        regs_in.sp = stack_start_ff;
                        stopped_in = 1'b0;
                     end
                  end
               endcase
            end
         end
         ENG_RDATA: begin
            if (out_free) begin
               done    = 1'b1;
               rd_word = mem_rdata;
            end
         end
         ENG_EXEC: begin
            op_in = mem_rdata[7:0];
            if (ex.load) begin
               // PC and B settle now, A lands with the data word
               mem_en     = 1'b1;
               mem_addr   = ex.mem_addr[AW-1:0];
               regs_in    = ex.regs;
               regs_in.a  = regs_ff.a;
            end else if (out_free) begin
               done       = 1'b1;
               regs_in    = ex.regs;
               stopped_in = stopped_ff | ex.stop;
               status     = ex.status;
               opc        = mem_rdata[7:0];
               if (ex.store) begin
                  mem_en    = 1'b1;
                  mem_we    = 1'b1;
                  mem_addr  = ex.mem_addr[AW-1:0];
                  mem_wdata = ex.wdata;
               end
            end
         end
         ENG_LOAD: begin
            if (out_free) begin
               done      = 1'b1;
               regs_in.a = mem_rdata;
               opc       = op_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_in.status      = status;
      rsp_in.read_data   = rd_word;
      rsp_in.opcode_done = opc;
      rsp_in.pc_out      = regs_in.pc;
      rsp_in.sp_out      = regs_in.sp;
      rsp_in.a_out       = regs_in.a;
      rsp_in.b_out       = regs_in.b;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ENG_CLEAR;
         clr_cnt_ff     <= '0;
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         regs_ff.a      <= '0;
         regs_ff.b      <= '0;
         regs_ff.pc     <= '0;
         regs_ff.sp     <= SP_RESET;
         stopped_ff     <= 1'b0;
         run_limit_ff   <= LIMIT_RESET;
         stack_start_ff <= SP_RESET;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         regs_ff    <= regs_in;
         stopped_ff <= stopped_in;
         if (req_valid && !req_stall) begin
            in_valid_ff <= 1'b1;
         end else if (take) begin
            in_valid_ff <= 1'b0;
         end
         if (done) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_RUN_LIMIT:   run_limit_ff   <= csr_wdata[LIMIT_W-1:0];
               CSR_STACK_START: stack_start_ff <= csr_wdata;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_ff <= req_payload;
      end
      if (done) begin
         rsp_ff <= rsp_in;
      end
      op_ff <= op_in;
   end

endmodule

### bench/tb.sv
// Self-checking bench for two_register_stack_machine_step_core.
// A scoreboard class keeps its own copy of the machine and memory and checks each result word;
// plain tasks drive the request and csr ports, a process the result stall. Depends on tsm_pkg.
`timescale 1ns / 1ps

module tb;
   import tsm_pkg::*;

   localparam int unsigned TOTAL_WORDS    = 1650;
   localparam int unsigned PHASES         = 6;
   localparam int unsigned HOLD_CYCLES    = 300;
   localparam int unsigned WATCHDOG_LIMIT = 20000;

   class machine_scoreboard;
      bit [31:0]   mem [4096];
      bit [31:0]   reg_a, reg_b, pc, sp, stack_start;
      bit [12:0]   run_limit;
      bit          stopped;
      rsp_type     expected_results [$];
      int unsigned mismatches, checked;
      int unsigned step_outcomes [8];

      function new();
         run_limit   = LIMIT_RESET;
         stack_start = SP_RESET;
         sp          = SP_RESET;
      endfunction

      // one instruction at pc; memory addresses wrap on the low 12 bits
      function status_type execute_instruction(output bit [7:0] op);
         bit [31:0] word, arg, ea;
         word = mem[pc[11:0]];
         op   = word[7:0];
         arg  = {{8{word[31]}}, word[31:8]};
         pc   = pc + 1;
         case (op)
            OP_LDC: begin
               reg_b = reg_a;
               reg_a = arg;
            end
            OP_ADC: reg_a = reg_a + arg;
            OP_LDL: begin
               ea    = sp + arg;
               reg_b = reg_a;
               reg_a = mem[ea[11:0]];
            end
            OP_STL: begin
               ea             = sp + arg;
               mem[ea[11:0]] = reg_a;
               reg_a          = reg_b;
            end
            OP_LDNL: begin
               ea    = reg_a + arg;
               reg_a = mem[ea[11:0]];
            end
            OP_STNL: begin
               ea             = reg_a + arg;
               mem[ea[11:0]] = reg_b;
            end
            OP_ADD: reg_a = reg_b + reg_a;
            OP_SUB: reg_a = reg_b - reg_a;
            OP_SHL: begin
               if (reg_a >= 32) reg_a = 32'd0;
               else reg_a = reg_b << reg_a[4:0];
            end
            OP_SHR: begin
               if (reg_a >= 32) reg_a = {32{reg_b[31]}};
               else reg_a = $signed(reg_b) >>> reg_a[4:0];
            end
            OP_ADJ: sp = sp + arg;
            OP_A2SP: begin
               sp    = reg_a;
               reg_a = reg_b;
            end
            OP_SP2A: begin
               reg_b = reg_a;
               reg_a = sp;
            end
            OP_CALL: begin
               reg_b = reg_a;
               reg_a = pc;
               pc    = pc + arg;
            end
            OP_RETURN: begin
               pc    = reg_a;
               reg_a = reg_b;
            end
            OP_BRZ: if (reg_a == 0) pc = pc + arg;
            OP_BRLZ: if (reg_a[31]) pc = pc + arg;
            OP_BR: pc = pc + arg;
            OP_HALT: begin
               stopped = 1'b1;
               return ST_HALT;
            end
            default: begin
               stopped = 1'b1;
               return ST_UNKNOWN;
            end
         endcase
         return ST_DONE;
      endfunction

      function void note_request(req_type r);
         rsp_type   e;
         bit [7:0] op;
         e = '0;
         case (action_type'(r.action))
            ACT_WRITE: mem[r.address] = r.write_data;
            ACT_READ: e.read_data = mem[r.address];
            ACT_STEP: begin
               if (stopped) e.status = ST_STOPPED;
               else if (pc > {19'd0, run_limit}) e.status = ST_PAST;
               else begin
                  e.status      = execute_instruction(op);
                  e.opcode_done = op;
               end
               step_outcomes[e.status]++;
            end
            default: begin
               pc      = 0;
               sp      = stack_start;
               reg_a   = 0;
               reg_b   = 0;
               stopped = 1'b0;
            end
         endcase
         e.pc_out = pc;
         e.sp_out = sp;
         e.a_out  = reg_a;
         e.b_out  = reg_b;
         expected_results = {expected_results, e};
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         checked++;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("tb: result word %0d arrived with nothing pending", checked);
            return;
         end
         want = expected_results.pop_front();
         if (got.status !== want.status || got.read_data !== want.read_data ||
             got.opcode_done !== want.opcode_done || got.pc_out !== want.pc_out ||
             got.sp_out !== want.sp_out || got.a_out !== want.a_out ||
             got.b_out !== want.b_out) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("tb: mismatch on result word %0d at %0t", checked, $time);
               $display("   want st=%0d rd=%h op=%h pc=%h sp=%h a=%h b=%h", want.status,
                        want.read_data, want.opcode_done, want.pc_out, want.sp_out,
                        want.a_out, want.b_out);
               $display("   got  st=%0d rd=%h op=%h pc=%h sp=%h a=%h b=%h", got.status,
                        got.read_data, got.opcode_done, got.pc_out, got.sp_out,
                        got.a_out, got.b_out);
            end
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   req_type           req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rsp_type           rsp_payload;
   logic              csr_we = 1'b0;
   logic              csr_index = 1'b0;
   logic [DATA_W-1:0] csr_wdata = '0;

   machine_scoreboard sb = new();
   int unsigned       words_sent = 0;

   two_register_stack_machine_step_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // both sides run gap-free over one window of the run
   function automatic bit sender_idles();
      return !(words_sent >= 800 && words_sent < 1100) && $urandom_range(99) < 32;
   endfunction

   function automatic bit receiver_idles();
      return !(sb.checked >= 800 && sb.checked < 1100) && $urandom_range(99) < 32;
   endfunction

   function automatic bit [31:0] instr(opcode_type op, int arg);
      bit [31:0] v;
      v = arg;
      return {v[23:0], op};
   endfunction

   function automatic bit [31:0] random_instruction();
      bit [7:0] op;
      int       arg;
      if ($urandom_range(99) < 92) op = 8'($urandom_range(18));
      else op = 8'($urandom_range(255, 19));
      case ($urandom_range(9))
         0: arg = $urandom();
         1, 2: arg = $urandom_range(40);
         default: arg = int'($urandom_range(16)) - 8;
      endcase
      return {arg[23:0], op};
   endfunction

   task automatic put_word(action_type act, bit [11:0] addr, bit [31:0] data);
      req_type w;
      w.action     = act;
      w.address    = addr;
      w.write_data = data;
      while (sender_idles()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= w;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_request(w);
      words_sent++;
   endtask

   task automatic put_control(action_type act);
      put_word(act, 12'($urandom()), $urandom());
   endtask

   task automatic apply_settings(bit [12:0] limit, bit [31:0] start);
      csr_we    <= 1'b1;
      csr_index <= CSR_RUN_LIMIT;
      csr_wdata <= {19'd0, limit};
      @(posedge clock);
      sb.run_limit = limit;
      csr_index <= CSR_STACK_START;
      csr_wdata <= start;
      @(posedge clock);
      sb.stack_start = start;
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic directed_checks();
      put_word(ACT_READ, 12'h000, 32'h0);
      put_word(ACT_WRITE, 12'hFFF, 32'hFFFF_FFFF);
      put_word(ACT_READ, 12'hFFF, 32'h0);
      put_word(ACT_WRITE, 12'd0, instr(OP_LDC, -8));
      put_word(ACT_WRITE, 12'd1, instr(OP_LDC, 40));
      put_word(ACT_WRITE, 12'd2, instr(OP_SHR, 0));   // count 40, sign fill
      put_word(ACT_WRITE, 12'd3, instr(OP_SHL, 0));   // count all ones, gives zero
      put_word(ACT_WRITE, 12'd4, instr(OP_LDL, 2050)); // sp + 2050 wraps to word 2
      put_word(ACT_WRITE, 12'd5, instr(OP_BRZ, 2));
      put_word(ACT_WRITE, 12'd6, instr(OP_HALT, 0));
      put_control(ACT_RESTART);
      repeat (8) put_control(ACT_STEP);               // last one finds the machine stopped
      // jump to the all-ones word: unknown opcode
      put_word(ACT_WRITE, 12'd0, instr(OP_BR, 4094));
      put_control(ACT_RESTART);
      repeat (2) put_control(ACT_STEP);
      // jump past the run limit
      put_control(ACT_RESTART);
      put_word(ACT_WRITE, 12'd0, instr(OP_BR, 5000));
      repeat (2) put_control(ACT_STEP);
   endtask

   task automatic run_program();
      int unsigned len, steps;
      len = $urandom_range(12, 3);
      for (int i = 0; i < len; i++) put_word(ACT_WRITE, 12'(i), random_instruction());
      if ($urandom_range(3) != 0) put_word(ACT_WRITE, 12'($urandom()), $urandom());
      if ($urandom_range(4) != 0) put_control(ACT_RESTART);
      steps = $urandom_range(2 * len + 4, len);
      for (int i = 0; i < steps; i++) begin
         if ($urandom_range(9) == 0) put_control(ACT_READ);
         put_control(ACT_STEP);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) sb.check_result(rsp_payload);
   end

   // result side: random stalls plus one long hold so the core backs up
   initial begin : result_side
      bit held;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && sb.checked >= 400) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= receiver_idles();
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb: watchdog, %0d cycles without a handshake", quiet);
      $display("tb: done, errors");
      $finish;
   end

   initial begin : stimulus
      int unsigned phase_end, pick;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: apply_settings(13'd4095, 32'd2048);
            1: apply_settings(13'd0, 32'd0);
            2: apply_settings(13'd4096, 32'hFFFF_FFFF);
            3: apply_settings(13'($urandom_range(4096)), $urandom());
            4: apply_settings(13'd31, 32'd4090);
            default: apply_settings(13'd12, $urandom());
         endcase
         if (p == 0) directed_checks();
         phase_end = (p + 1) * TOTAL_WORDS / PHASES;
         while (words_sent < phase_end) begin
            pick = $urandom_range(99);
            if (pick < 70) run_program();
            else if (pick < 85) repeat ($urandom_range(8, 1)) put_control(ACT_STEP);
            else put_control(action_type'($urandom_range(3)));
         end
         drain();
      end
      $display("tb: %0d words over %0d csr settings, %0d results checked, %0d mismatches",
               words_sent, PHASES, sb.checked, sb.mismatches);
      $display("tb: steps done %0d, halt %0d, unknown %0d, past limit %0d, stopped %0d",
               sb.step_outcomes[ST_DONE], sb.step_outcomes[ST_HALT],
               sb.step_outcomes[ST_UNKNOWN], sb.step_outcomes[ST_PAST],
               sb.step_outcomes[ST_STOPPED]);
      if (sb.mismatches == 0 && sb.expected_results.size() == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule

### two_register_stack_machine_step_core.f
design/tsm_pkg.sv
design/tsm_mem.sv
design/tsm_exec.sv
design/two_register_stack_machine_step_core.sv
bench/tb.sv
